// ----- design/snap_pkg.sv -----
// shared types and constants for the single-neuron adaptive pid core
`timescale 1ns / 1ps
package snap_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_GAIN = 3'd1;
  localparam logic [2:0] REG_RATE_P = 3'd2;
  localparam logic [2:0] REG_RATE_I = 3'd3;
  localparam logic [2:0] REG_RATE_D = 3'd4;
  localparam logic [2:0] REG_SW_P = 3'd5;
  localparam logic [2:0] REG_SW_I = 3'd6;
  localparam logic [2:0] REG_SW_D = 3'd7;

  // learning rules
  localparam logic [1:0] MODE_HEBB = 2'd0;
  localparam logic [1:0] MODE_ERR = 2'd1;
  localparam logic [1:0] MODE_SUP = 2'd2;
  localparam logic [1:0] MODE_IMP = 2'd3;

  // reset values
  localparam logic [1:0] MODE_RESET = MODE_SUP;
  localparam logic [30:0] GAIN_RESET = 31'd65536;
  localparam logic [30:0] RATE_RESET = 31'd6554;
  localparam logic signed [31:0] WEIGHT_RESET = 32'sd65536;

  // request to the serial divider
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [33:0] den;
  } div_req_t;

endpackage

// ----- design/single_neuron_adaptive_pid_core.sv -----
// single-neuron adaptive pid core: sequencer, registers and state
// the hebbian and error rules skip the third learning product; a zero norm skips the division
// throughput: one sample at a time; input stalls until the result is in the output register
// one shared 33x33 multiplier and one serial divider carry all products and quotients
// reset: async active low; registers take their reset values, weights 1.0, history zero
`timescale 1ns / 1ps
module single_neuron_adaptive_pid_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  target_i,
  input  logic signed [31:0]  measured_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  drive_o,
  output logic                zero_norm_o
);

  localparam int ACC_W = FRAC_BITS + 36;
  localparam logic signed [66:0] HALF = 67'sd1 <<< (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ERR, ST_LM1, ST_LM2, ST_LM3, ST_LADD, ST_NORM,
    ST_DIVGO, ST_DIVW, ST_MAC, ST_GAIN, ST_DRV, ST_OUT
  } state_e;

  function automatic logic signed [31:0] sat67(input logic signed [66:0] v);
    logic signed [31:0] r;
    if (v > 67'sd2147483647) r = 32'sh7fffffff;
    else if (v < -67'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // round half up, floor shift, saturate
  function automatic logic signed [31:0] qfix(input logic signed [65:0] p);
    logic signed [66:0] v;
    v = 67'(p) + HALF;
    v = v >>> FRAC_BITS;
    return sat67(v);
  endfunction

  // configuration registers
  logic [1:0]  mode_q;
  logic [30:0] gain_q;
  logic [30:0] rate_q [3];
  logic [31:0] sw_q [3];
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= snap_pkg::MODE_RESET;
      gain_q <= snap_pkg::GAIN_RESET;
      for (int k = 0; k < 3; k++) begin
        rate_q[k] <= snap_pkg::RATE_RESET;
        sw_q[k]   <= snap_pkg::WEIGHT_RESET;
      end
    end else if (wr_en) begin
      case (paddr[4:2])
        snap_pkg::REG_MODE:   mode_q    <= pwdata[1:0];
        snap_pkg::REG_GAIN:   gain_q    <= pwdata[30:0];
        snap_pkg::REG_RATE_P: rate_q[0] <= pwdata[30:0];
        snap_pkg::REG_RATE_I: rate_q[1] <= pwdata[30:0];
        snap_pkg::REG_RATE_D: rate_q[2] <= pwdata[30:0];
        snap_pkg::REG_SW_P:   sw_q[0]   <= pwdata;
        snap_pkg::REG_SW_I:   sw_q[1]   <= pwdata;
        snap_pkg::REG_SW_D:   sw_q[2]   <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:2])
      snap_pkg::REG_MODE:   prdata = {30'd0, mode_q};
      snap_pkg::REG_GAIN:   prdata = {1'b0, gain_q};
      snap_pkg::REG_RATE_P: prdata = {1'b0, rate_q[0]};
      snap_pkg::REG_RATE_I: prdata = {1'b0, rate_q[1]};
      snap_pkg::REG_RATE_D: prdata = {1'b0, rate_q[2]};
      snap_pkg::REG_SW_P:   prdata = sw_q[0];
      snap_pkg::REG_SW_I:   prdata = sw_q[1];
      snap_pkg::REG_SW_D:   prdata = sw_q[2];
      default:              prdata = '0;
    endcase
  end

  // sequencer state and datapath registers
  state_e                    state_q;
  logic [1:0]                sel_q;
  logic signed [31:0]        tgt_q, meas_q, e_q, imp_q;
  logic signed [31:0]        w_q [3];
  logic signed [31:0]        inc_q [3];
  logic signed [31:0]        drive_q, el_q, eb_q;
  logic [33:0]               norm_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic                      zero_q;
  logic                      out_valid_q, out_zero_q;
  logic signed [31:0]        out_drive_q;

  // shared multiplier operands
  logic                      mul_en;
  logic signed [32:0]        mul_a, mul_b;
  logic signed [65:0]        prod;
  logic signed [31:0]        pfix;

  snap_pkg::div_req_t        div_req;
  logic                      div_done;
  logic [FRAC_BITS:0]        div_quot;
  logic signed [FRAC_BITS+1:0] nw;

  // error and improved term
  logic signed [31:0] e_c, imp_c;
  logic [31:0]        abs_w [3];
  logic [33:0]        norm_c;

  assign pfix  = qfix(prod);
  assign e_c   = sat67(67'(tgt_q) - 67'(meas_q));
  assign imp_c = sat67((67'(e_c) <<< 1) - 67'(el_q));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      abs_w[k] = w_q[k][31] ? 32'(-w_q[k]) : 32'(w_q[k]);
    end
    norm_c = {2'b00, abs_w[0]} + {2'b00, abs_w[1]} + {2'b00, abs_w[2]};
  end

  assign nw = w_q[sel_q][31] ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

  // operand selection for the multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      ST_LM1: begin
        mul_en = 1'b1;
        mul_a  = $signed({2'b00, rate_q[sel_q]});
        mul_b  = 33'(drive_q);
      end
      ST_LM2: begin
        mul_en = 1'b1;
        mul_a  = 33'(pfix);
        mul_b  = (mode_q == snap_pkg::MODE_HEBB) ? 33'(inc_q[sel_q]) : 33'(e_q);
      end
      ST_LM3: begin
        mul_en = 1'b1;
        mul_a  = 33'(pfix);
        mul_b  = (mode_q == snap_pkg::MODE_SUP) ? 33'(inc_q[sel_q]) : 33'(imp_q);
      end
      ST_DIVW: begin
        mul_en = div_done;
        mul_a  = 33'(nw);
        mul_b  = 33'(inc_q[sel_q]);
      end
      ST_GAIN: begin
        mul_en = 1'b1;
        mul_a  = $signed({2'b00, gain_q});
        mul_b  = 33'(sat67((67'(acc_q) + HALF) >>> FRAC_BITS));
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req.start = (state_q == ST_DIVGO);
    div_req.num   = abs_w[sel_q];
    div_req.den   = norm_q;
  end

  snap_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  snap_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= '0;
      drive_q     <= '0;
      el_q        <= '0;
      eb_q        <= '0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        w_q[k]   <= snap_pkg::WEIGHT_RESET;
        inc_q[k] <= '0;
      end
    end else begin
      // result beat valid: set on load, cleared on acceptance
      if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            tgt_q   <= target_i;
            meas_q  <= measured_i;
            state_q <= ST_ERR;
          end
        end
        ST_ERR: begin
          e_q     <= e_c;
          imp_q   <= imp_c;
          sel_q   <= '0;
          state_q <= ST_LM1;
        end
        ST_LM1: state_q <= ST_LM2;
        ST_LM2: begin
          if (mode_q == snap_pkg::MODE_HEBB || mode_q == snap_pkg::MODE_ERR) begin
            state_q <= ST_LADD;
          end else begin
            state_q <= ST_LM3;
          end
        end
        ST_LM3: state_q <= ST_LADD;
        ST_LADD: begin
          w_q[sel_q] <= sat67(67'(w_q[sel_q]) + 67'(pfix));
          if (sel_q == 2'd2) begin
            state_q <= ST_NORM;
          end else begin
            sel_q   <= sel_q + 2'd1;
            state_q <= ST_LM1;
          end
        end
        ST_NORM: begin
          // new increments and error history
          inc_q[0] <= sat67(67'(e_q) - 67'(el_q));
          inc_q[1] <= e_q;
          inc_q[2] <= sat67(67'(e_q) - (67'(el_q) <<< 1) + 67'(eb_q));
          eb_q     <= el_q;
          el_q     <= e_q;
          norm_q   <= norm_c;
          sel_q    <= '0;
          acc_q    <= '0;
          zero_q   <= (norm_c == '0);
          state_q  <= (norm_c == '0) ? ST_OUT : ST_DIVGO;
        end
        ST_DIVGO: state_q <= ST_DIVW;
        ST_DIVW: begin
          if (div_done) state_q <= ST_MAC;
        end
        ST_MAC: begin
          acc_q <= acc_q + ACC_W'(prod);
          if (sel_q == 2'd2) begin
            state_q <= ST_GAIN;
          end else begin
            sel_q   <= sel_q + 2'd1;
            state_q <= ST_DIVGO;
          end
        end
        ST_GAIN: state_q <= ST_DRV;
        ST_DRV: begin
          drive_q <= sat67(67'(drive_q) + 67'(pfix));
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_drive_q <= drive_q;
            out_zero_q  <= zero_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign drive_o     = out_drive_q;
  assign zero_norm_o = out_zero_q;

  // a result beat is loaded only from the output step
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result beat loaded outside output step");

  // normalized magnitude never exceeds one
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (div_quot <= (FRAC_BITS+1)'(1) << FRAC_BITS))
    else $error("normalized weight above one");

  // zero norm holds the drive
  a_zero_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NORM && norm_c == '0) |=> (drive_q == $past(drive_q)))
    else $error("drive changed on zero norm");

endmodule

// ----- design/snap_mul.sv -----
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module snap_mul (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [32:0]  a_i,
  input  logic signed [32:0]  b_i,
  output logic signed [65:0]  p_o
);

  logic signed [65:0] p_q;

  // one product per enabled cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// ----- design/snap_div.sv -----
// serial restoring divider for weight normalization, one quotient bit per cycle
`timescale 1ns / 1ps
module snap_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  snap_pkg::div_req_t   req_i,
  output logic                 done_o,
  output logic [FRAC_BITS:0]   quot_o
);

  localparam int CNT_W = $clog2(FRAC_BITS + 2);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(FRAC_BITS);

  logic [35:0]        rem_q, rem_d;
  logic [33:0]        den_q;
  logic [FRAC_BITS:0] quot_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q, first_q, done_q;
  logic [35:0]        trial;

  // numerator never exceeds the divisor, so the quotient fits in FRAC_BITS+1 bits
  assign trial = first_q ? rem_q : {rem_q[34:0], 1'b0};
  assign rem_d = (trial >= {2'b00, den_q}) ? trial - {2'b00, den_q} : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        first_q <= 1'b1;
        cnt_q   <= '0;
      end else if (busy_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= {4'd0, req_i.num};
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[FRAC_BITS-1:0], (trial >= {2'b00, den_q})};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- verif/single_neuron_adaptive_pid_core_test.sv -----
// testbench for the single-neuron adaptive pid core: directed table, then random phases
`timescale 1ns / 1ps
module single_neuron_adaptive_pid_core_test;

  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 240;
  localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S_MIN = 32'sh80000000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [2:0]         idx;
    logic [31:0]        data;
    logic signed [31:0] tgt;
    logic signed [31:0] meas;
    logic               chk;
    logic signed [31:0] drv;
    logic               zn;
  } step_row_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               zero_norm;
  } drive_beat_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [31:0] target_i;
  logic signed [31:0] measured_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [31:0] drive_o;
  logic zero_norm_o;

  single_neuron_adaptive_pid_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .target_i(target_i), .measured_i(measured_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .drive_o(drive_o), .zero_norm_o(zero_norm_o)
  );

  // directed table; typed drive values only where obvious
  step_row_t dir_rows [] = '{
    '{ROW_ITEM, snap_pkg::REG_MODE, 32'd0, 32'sd65536, 32'sd0, 1'b1, 32'sd65535, 1'b0},
    '{ROW_CFG, snap_pkg::REG_MODE, 32'(snap_pkg::MODE_ERR), 32'sd0, 32'sd0,
      1'b0, 32'sd0, 1'b0},
    '{ROW_CFG, snap_pkg::REG_RATE_P, 32'd65537, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_CFG, snap_pkg::REG_RATE_I, 32'd65537, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_CFG, snap_pkg::REG_RATE_D, 32'd65537, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    // weights cancel to zero: drive held, flag raised
    '{ROW_ITEM, snap_pkg::REG_MODE, 32'd0, 32'sd0, 32'sd65536, 1'b1, 32'sd65535, 1'b1},
    '{ROW_ITEM, snap_pkg::REG_MODE, 32'd0, 32'sd0, 32'sd0, 1'b1, 32'sd65535, 1'b1},
    '{ROW_CFG, snap_pkg::REG_MODE, 32'(snap_pkg::MODE_HEBB), 32'sd0, 32'sd0,
      1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, snap_pkg::REG_MODE, 32'd0, S_MAX, S_MIN, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, snap_pkg::REG_MODE, 32'd0, S_MIN, S_MAX, 1'b0, 32'sd0, 1'b0},
    '{ROW_CFG, snap_pkg::REG_MODE, 32'(snap_pkg::MODE_IMP), 32'sd0, 32'sd0,
      1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, snap_pkg::REG_MODE, 32'd0, 32'sd1234567, -32'sd7654321,
      1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, snap_pkg::REG_MODE, 32'd0, S_MIN, S_MIN, 1'b0, 32'sd0, 1'b0},
    '{ROW_CFG, snap_pkg::REG_GAIN, 32'hffffffff, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, snap_pkg::REG_MODE, 32'd0, S_MAX, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_CFG, snap_pkg::REG_GAIN, 32'd0, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, snap_pkg::REG_MODE, 32'd0, -32'sd5000, 32'sd300, 1'b0, 32'sd0, 1'b0},
    '{ROW_CFG, snap_pkg::REG_RATE_P, 32'd0, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_CFG, snap_pkg::REG_RATE_I, 32'h7fffffff, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_CFG, snap_pkg::REG_SW_P, 32'd0, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_CFG, snap_pkg::REG_SW_I, 32'h80000000, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_CFG, snap_pkg::REG_SW_D, 32'h7fffffff, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_CFG, snap_pkg::REG_MODE, 32'(snap_pkg::MODE_SUP), 32'sd0, 32'sd0,
      1'b0, 32'sd0, 1'b0},
    '{ROW_CFG, snap_pkg::REG_GAIN, 32'd65536, 32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, snap_pkg::REG_MODE, 32'd0, S_MAX, S_MAX, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, snap_pkg::REG_MODE, 32'd0, -32'sd65536, 32'sd65536, 1'b0, 32'sd0, 1'b0}
  };

  // register shadow and controller state of the predictor
  logic [31:0] reg_shadow [8];
  logic signed [31:0] wt [3];
  logic signed [31:0] incr [3];
  logic signed [31:0] drive_acc, err_last, err_prev;

  drive_beat_t drive_q [$];
  int errors = 0;
  int cycles = 0;
  int tx_pct = 0;
  int rx_pct = 0;
  bit hold_req = 0;

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > longint'(S_MAX)) return S_MAX;
    if (v < longint'(S_MIN)) return S_MIN;
    return v[31:0];
  endfunction

  // rounded fixed-point product, saturated
  function automatic logic signed [31:0] qmul(input longint a, input longint b);
    return sat32((a * b + (longint'(1) <<< (FRAC - 1))) >>> FRAC);
  endfunction

  function automatic logic [31:0] reg_mask(input logic [2:0] idx);
    case (idx)
      snap_pkg::REG_MODE: return 32'h3;
      snap_pkg::REG_SW_P, snap_pkg::REG_SW_I, snap_pkg::REG_SW_D: return 32'hffffffff;
      default: return 32'h7fffffff;
    endcase
  endfunction

  function automatic logic signed [31:0] learn_weight(
    input logic signed [31:0] w, input logic [30:0] rate, input logic signed [31:0] inc,
    input logic signed [31:0] e, input logic signed [31:0] imp, input logic [1:0] mode);
    logic signed [31:0] t;
    t = qmul(longint'({33'd0, rate}), drive_acc);
    case (mode)
      snap_pkg::MODE_HEBB: t = qmul(t, inc);
      snap_pkg::MODE_ERR: t = qmul(t, e);
      snap_pkg::MODE_SUP: t = qmul(qmul(t, e), inc);
      default: t = qmul(qmul(t, e), imp);
    endcase
    return sat32(longint'(w) + t);
  endfunction

  // advance the controller by one sample and return the expected beat
  function automatic drive_beat_t next_drive(input logic signed [31:0] tg,
                                             input logic signed [31:0] ms);
    drive_beat_t r;
    logic signed [31:0] e, imp, s, delta;
    longint nrm, sum, nw;
    e = sat32(longint'(tg) - ms);
    imp = sat32(2 * longint'(e) - err_last);
    for (int k = 0; k < 3; k++)
      wt[k] = learn_weight(wt[k], reg_shadow[int'(snap_pkg::REG_RATE_P) + k][30:0],
                           incr[k], e, imp, reg_shadow[snap_pkg::REG_MODE][1:0]);
    incr[0] = sat32(longint'(e) - err_last);
    incr[1] = e;
    incr[2] = sat32(longint'(e) - 2 * longint'(err_last) + err_prev);
    nrm = 0;
    for (int k = 0; k < 3; k++)
      nrm += (wt[k] < 0) ? -longint'(wt[k]) : longint'(wt[k]);
    r.zero_norm = (nrm == 0);
    if (nrm != 0) begin
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        nw = (longint'(wt[k]) * (longint'(1) <<< FRAC)) / nrm;
        sum += nw * incr[k];
      end
      s = sat32((sum + (longint'(1) <<< (FRAC - 1))) >>> FRAC);
      delta = qmul(longint'({33'd0, reg_shadow[snap_pkg::REG_GAIN][30:0]}), s);
      drive_acc = sat32(longint'(drive_acc) + delta);
    end
    err_prev = err_last;
    err_last = e;
    r.drive = drive_acc;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // clock and cycle limit
  initial begin
    clk_i = 1'b0;
    forever begin
      #2 clk_i = ~clk_i;
      if (clk_i) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
          $display("single_neuron_adaptive_pid_core test failed");
          $finish;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin : rx_proc
    int hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_pct);
      end
    end
  end

  // check each accepted result beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (drive_q.size() == 0) begin
        report("unexpected beat", drive_o, 32'd0);
      end else begin
        if (drive_o !== drive_q[0].drive) report("drive", drive_o, drive_q[0].drive);
        if (zero_norm_o !== drive_q[0].zero_norm)
          report("zero_norm", 32'(zero_norm_o), 32'(drive_q[0].zero_norm));
        void'(drive_q.pop_front());
      end
    end
  end

  // offer one sample, return in the step it is accepted
  task automatic send_sample(input logic signed [31:0] tg, input logic signed [31:0] ms,
                             input bit typed, input drive_beat_t typed_beat);
    drive_beat_t b;
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_i <= tg;
    measured_i <= ms;
    do @(posedge clk_i); while (in_stall_o);
    b = next_drive(tg, ms);
    drive_q.push_back(typed ? typed_beat : b);
  endtask

  // stop offering and wait until every result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // register write then readback
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    paddr <= {idx, 2'b00};
    pwdata <= val;
    pwrite <= 1'b1;
    psel <= 1'b1;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    reg_shadow[idx] = val & reg_mask(idx);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== reg_shadow[idx]) report("register readback", prdata, reg_shadow[idx]);
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_signal();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return S_MAX;
          1: return S_MIN;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      1, 2: return $urandom;
      default: return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
    endcase
  endfunction

  function automatic logic [31:0] rand_rate();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'd0;
      default: return $urandom_range(0, 20000);
    endcase
  endfunction

  // main sequence
  initial begin : main_proc
    drive_beat_t tb;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    target_i = '0;
    measured_i = '0;
    reg_shadow[snap_pkg::REG_MODE] = 32'(snap_pkg::MODE_RESET);
    reg_shadow[snap_pkg::REG_GAIN] = 32'(snap_pkg::GAIN_RESET);
    for (int k = 0; k < 3; k++) begin
      reg_shadow[int'(snap_pkg::REG_RATE_P) + k] = 32'(snap_pkg::RATE_RESET);
      reg_shadow[int'(snap_pkg::REG_SW_P) + k] = snap_pkg::WEIGHT_RESET;
      wt[k] = snap_pkg::WEIGHT_RESET;
      incr[k] = '0;
    end
    drive_acc = '0;
    err_last = '0;
    err_prev = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        tb.drive = dir_rows[i].drv;
        tb.zero_norm = dir_rows[i].zn;
        send_sample(dir_rows[i].tgt, dir_rows[i].meas, dir_rows[i].chk, tb);
      end
    end
    drain();

    // random phases, one idling pattern and one setting each
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      tx_pct = (ph % 4 == 1) ? 63 : (ph % 4 == 3) ? 33 : 0;
      rx_pct = (ph % 4 == 2) ? 63 : (ph % 4 == 3) ? 33 : 0;
      write_reg(snap_pkg::REG_MODE, $urandom);
      write_reg(snap_pkg::REG_GAIN,
                ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 196608));
      write_reg(snap_pkg::REG_RATE_P, rand_rate());
      write_reg(snap_pkg::REG_RATE_I, rand_rate());
      write_reg(snap_pkg::REG_RATE_D, rand_rate());
      write_reg(snap_pkg::REG_SW_P + 3'(ph % 3), $urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 1 && n == 40) hold_req = 1;
        if (ph == 2 && n == 100) begin
          in_valid_i <= 1'b0;
          while (drive_q.size() != 0) @(posedge clk_i);
        end
        send_sample(rand_signal(), rand_signal(), 1'b0, tb);
      end
      drain();
    end

    // final wait for stragglers, bounded
    in_valid_i <= 1'b0;
    repeat (120) @(posedge clk_i);
    if (errors == 0 && drive_q.size() == 0) begin
      $display("single_neuron_adaptive_pid_core test passed");
    end else begin
      $display("single_neuron_adaptive_pid_core test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/snap_pkg.sv
design/snap_mul.sv
design/snap_div.sv
design/single_neuron_adaptive_pid_core.sv
verif/single_neuron_adaptive_pid_core_test.sv
